/* hw/rtl/lft_pkg.sv */
`default_nettype none

package lft_pkg;

    // Longest format string that is parsed; positions past it flag an error.
    localparam int MAX_FORMAT_LEN = 256;

    // Position counter saturates at 256, so it needs one bit more than a byte.
    localparam int POS_W = 9;
    localparam int POS_SAT = 256;
    localparam int POS_LIMIT = (MAX_FORMAT_LEN < POS_SAT) ? MAX_FORMAT_LEN : POS_SAT;

    localparam int KIND_W = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ESCAPE = 2'd0;
    localparam logic [1:0] CFG_OPEN   = 2'd1;
    localparam logic [1:0] CFG_CLOSE  = 2'd2;

    localparam logic [7:0] RST_ESCAPE = 8'd37;
    localparam logic [7:0] RST_OPEN   = 8'd123;
    localparam logic [7:0] RST_CLOSE  = 8'd125;

    // Segment kinds.
    localparam logic [KIND_W-1:0] KIND_PERCENT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_H       = 4'd1;
    localparam logic [KIND_W-1:0] KIND_L       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_U       = 4'd3;
    localparam logic [KIND_W-1:0] KIND_T       = 4'd4;
    localparam logic [KIND_W-1:0] KIND_R       = 4'd5;
    localparam logic [KIND_W-1:0] KIND_S       = 4'd6;
    localparam logic [KIND_W-1:0] KIND_B       = 4'd7;
    localparam logic [KIND_W-1:0] KIND_I       = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LITERAL = 4'd9;

    // Parser states, one-hot.
    typedef enum logic [3:0] {
        ST_LIT   = 4'b0001,
        ST_ESC   = 4'b0010,
        ST_AFTER = 4'b0100,
        ST_BRACE = 4'b1000
    } t_parse_state;

    typedef struct packed {
        logic [7:0] escape_char;
        logic [7:0] open_char;
        logic [7:0] close_char;
    } t_cfg;

    // Parser context carried from one byte to the next.
    typedef struct packed {
        t_parse_state     state;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] seg_begin;
        logic             err;
    } t_ctx;

    typedef struct packed {
        logic              has_segment;
        logic [7:0]        seg_start;
        logic [7:0]        seg_end;
        logic [KIND_W-1:0] seg_kind;
        logic              format_done;
        logic              format_error;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
        t_ctx    next;
    } t_step;

    // Modifier letter lookup: bit KIND_W is the hit flag, the rest the kind.
    function automatic logic [KIND_W:0] lookup_modifier(input logic [7:0] c);
        logic [KIND_W:0] r;
        r = '0;
        case (c)
            8'h25: r = {1'b1, KIND_PERCENT};
            8'h68: r = {1'b1, KIND_H};
            8'h6C: r = {1'b1, KIND_L};
            8'h75: r = {1'b1, KIND_U};
            8'h74: r = {1'b1, KIND_T};
            8'h72: r = {1'b1, KIND_R};
            8'h73: r = {1'b1, KIND_S};
            8'h62: r = {1'b1, KIND_B};
            8'h69: r = {1'b1, KIND_I};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/log_format_tokenizer.sv */
// Channel  | Direction | Handshake                      | Contents
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: ch; tlast: last_byte
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: segment; tlast: format_done;
//          |           |                                | tuser: format_error
// cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One byte is accepted every cycle while the input is not stalled; its result, if any,
// is written to the output register by the single parse step between context and result.
// A byte yields at most one result; the final byte always yields one.
// Reset is synchronous and active low; it restores the default delimiters.
// The input is stalled only while the output register is full and not taken.
`default_nettype none

module log_format_tokenizer
    import lft_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,   // last_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [0] has_segment, [8:1] seg_start,
                                             // [16:9] seg_end, [20:17] seg_kind, rest zero
    output logic             m_axis_tlast,   // format_done
    output logic             m_axis_tuser,   // [0] format_error

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_ctx    r_ctx;
    logic    r_out_valid;
    t_result r_out;
    t_step   step;
    logic    in_req;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    lft_step u_step (
        .i_ch   (s_axis_tdata),
        .i_last (s_axis_tlast),
        .i_cfg  (r_cfg),
        .i_ctx  (r_ctx),
        .o_step (step)
    );

    // Delimiter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_char <= RST_ESCAPE;
            r_cfg.open_char   <= RST_OPEN;
            r_cfg.close_char  <= RST_CLOSE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ESCAPE: r_cfg.escape_char <= i_cfg_data;
                CFG_OPEN:   r_cfg.open_char   <= i_cfg_data;
                CFG_CLOSE:  r_cfg.close_char  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Parser context; the final byte returns it to the idle values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state     <= ST_LIT;
            r_ctx.pos       <= '0;
            r_ctx.seg_begin <= '0;
            r_ctx.err       <= 1'b0;
        end else if (in_req) begin
            if (s_axis_tlast) begin
                r_ctx.state     <= ST_LIT;
                r_ctx.pos       <= '0;
                r_ctx.seg_begin <= '0;
                r_ctx.err       <= 1'b0;
            end else begin
                r_ctx <= step.next;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_req) begin
            r_out_valid <= step.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (in_req && step.emit) begin
            r_out <= step.result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.seg_kind, r_out.seg_end, r_out.seg_start,
                            r_out.has_segment};
    assign m_axis_tlast  = r_out.format_done;
    assign m_axis_tuser  = r_out.format_error;

endmodule

`default_nettype wire

/* hw/rtl/lft_step.sv */
`default_nettype none

module lft_step
    import lft_pkg::*;
(
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    input  wire t_cfg       i_cfg,
    input  wire t_ctx       i_ctx,
    output t_step           o_step
);

    logic            lit_emit;
    logic            mod_emit;
    logic            end_emit;
    logic [KIND_W:0] lookup;
    logic            mod_hit;
    logic            mod_expr;
    logic            err_mid;
    t_ctx            mid;
    t_ctx            nxt;
    t_result         res;

    assign lookup   = lookup_modifier(i_ch);
    assign mod_hit  = lookup[KIND_W];
    assign mod_expr = (lookup[KIND_W-1:0] == KIND_T) || (lookup[KIND_W-1:0] == KIND_I);

    // Per-byte parse: state transition and any segment that the byte closes.
    always_comb begin
        mid      = i_ctx;
        lit_emit = 1'b0;
        mod_emit = 1'b0;
        err_mid  = i_ctx.err || (i_ctx.pos >= POS_W'(POS_LIMIT));
        if (!err_mid) begin
            unique case (i_ctx.state)
                ST_BRACE: begin
                    if (i_ch == i_cfg.close_char) begin
                        mid.state = ST_AFTER;
                    end else if (i_ch == i_cfg.open_char) begin
                        err_mid = 1'b1;
                    end
                end
                ST_ESC, ST_AFTER: begin
                    if (i_ctx.state == ST_ESC && i_ch == i_cfg.open_char) begin
                        mid.state = ST_BRACE;
                    end else if (!mod_hit || (i_ctx.state == ST_AFTER && !mod_expr)) begin
                        err_mid = 1'b1;
                    end else begin
                        mod_emit      = 1'b1;
                        mid.seg_begin = i_ctx.pos + POS_W'(1);
                        mid.state     = ST_LIT;
                    end
                end
                ST_LIT: begin
                    if (i_ch == i_cfg.escape_char) begin
                        lit_emit      = (i_ctx.seg_begin != i_ctx.pos);
                        mid.seg_begin = i_ctx.pos;
                        mid.state     = ST_ESC;
                    end
                end
                default: begin
                    err_mid = 1'b1;
                end
            endcase
        end
        mid.err = err_mid;
        if (i_ctx.pos < POS_W'(POS_SAT)) begin
            mid.pos = i_ctx.pos + POS_W'(1);
        end
    end

    // Closing literal run on the final byte, and the error for a dangling escape.
    always_comb begin
        end_emit = 1'b0;
        nxt      = mid;
        if (i_last) begin
            if (!mid.err) begin
                if (mid.state != ST_LIT) begin
                    nxt.err = 1'b1;
                end else if (mid.seg_begin <= i_ctx.pos) begin
                    end_emit = 1'b1;
                end
            end
        end
    end

    // Result assembly; at most one segment can fall on any one byte.
    always_comb begin
        res = '0;
        if (mod_emit) begin
            res.has_segment = 1'b1;
            res.seg_start   = i_ctx.seg_begin[7:0];
            res.seg_end     = i_ctx.pos[7:0];
            res.seg_kind    = lookup[KIND_W-1:0];
        end else if (lit_emit) begin
            res.has_segment = 1'b1;
            res.seg_start   = i_ctx.seg_begin[7:0];
            res.seg_end     = 8'(i_ctx.pos - POS_W'(1));
            res.seg_kind    = KIND_LITERAL;
        end else if (end_emit) begin
            res.has_segment = 1'b1;
            res.seg_start   = mid.seg_begin[7:0];
            res.seg_end     = i_ctx.pos[7:0];
            res.seg_kind    = KIND_LITERAL;
        end
        if (i_last) begin
            res.format_done  = 1'b1;
            res.format_error = nxt.err;
        end
    end

    // Packed in member order: emit flag, result, next context.
    assign o_step = {mod_emit || lit_emit || end_emit || i_last, res, nxt};

endmodule

`default_nettype wire
